// ===== sv/rtvt_pkg.sv =====
// rotary token value tracker package: shared types, constants and the value map
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtvt_pkg;

	localparam int NUM_TOKENS = 3;
	localparam int ANGLE_W    = 13;
	localparam int DELTA_W    = 15;
	localparam int SUM_W      = 16;
	localparam int VALUE_W    = 8;
	localparam int REGION_W   = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BLUE  = 2'd2;

	localparam logic [REGION_W-1:0] REGION_RED_RST   = 32'h0904_0A05;
	localparam logic [REGION_W-1:0] REGION_GREEN_RST = 32'h0904_1B16;
	localparam logic [REGION_W-1:0] REGION_BLUE_RST  = 32'h1914_1B16;

	localparam logic signed [DELTA_W-1:0] HALF_TURN = 15'sd2880;
	localparam logic signed [DELTA_W-1:0] FULL_TURN = 15'sd5760;
	localparam logic signed [DELTA_W-1:0] DEAD_BAND = 15'sd112;
	localparam logic [VALUE_W-1:0]        INIT_VALUE = 8'd128;
	localparam logic [VALUE_W-1:0]        MAX_VALUE  = 8'd255;

	typedef struct packed {
		logic               changed;
		logic [VALUE_W-1:0] value;
	} token_upd_t;

	// floor((acc + 2880) * 255 / 57600) * 10 for acc below 2880
	// 255/57600 = 17/3840; /3840 done as >>8 then *4370>>16 (exact below 383)
	function automatic logic [VALUE_W-1:0] map_value(input logic signed [ANGLE_W-1:0] acc);
		logic signed [ANGLE_W:0] n_s;
		logic [16:0]             m;
		logic [21:0]             p;
		logic [5:0]              q;
		logic [9:0]              v;
		n_s = {acc[ANGLE_W-1], acc} + 14'sd2880;
		m   = 17'(n_s[ANGLE_W-1:0]) * 17'd17;
		p   = 22'(m[16:8]) * 22'd4370;
		q   = p[21:16];
		v   = 10'(q) * 10'd10;
		return v[VALUE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/rtvt_token.sv =====
// per-token rotation state and update logic
// depends on rtvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtvt_token import rtvt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               hit,
	input  wire logic               commit,
	input  wire logic [ANGLE_W-1:0] angle,
	output token_upd_t              upd
);

	logic                       ready_q;
	logic [ANGLE_W-1:0]         last_q;
	logic signed [ANGLE_W-1:0]  acc_q;
	logic [VALUE_W-1:0]         value_q;

	logic signed [DELTA_W-1:0]  d_raw;
	logic signed [DELTA_W-1:0]  d;
	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    acc_clamped;
	logic signed [ANGLE_W-1:0]  acc_new;
	logic [VALUE_W-1:0]         value_new;
	logic                       small_step;
	logic                       init;
	logic                       step;

	always_comb begin
		d_raw = signed'({2'b00, angle}) - signed'({2'b00, last_q});
		// unwrap across the seam
		if (d_raw > HALF_TURN || d_raw < -HALF_TURN) begin
			if ({2'b00, last_q} > 15'(HALF_TURN))
				d = d_raw + FULL_TURN;
			else
				d = d_raw - FULL_TURN;
		end else begin
			d = d_raw;
		end
		small_step = (d <= DEAD_BAND) && (d >= -DEAD_BAND);
		sum = SUM_W'(acc_q) + SUM_W'(d);
		if (d > 0)
			acc_clamped = (sum > SUM_W'(HALF_TURN)) ? SUM_W'(HALF_TURN) : sum;
		else
			acc_clamped = (sum < -SUM_W'(HALF_TURN)) ? -SUM_W'(HALF_TURN) : sum;
		acc_new = acc_clamped[ANGLE_W-1:0];
		if (acc_clamped >= SUM_W'(HALF_TURN))
			value_new = MAX_VALUE;
		else
			value_new = map_value(acc_new);

		init = hit && !ready_q;
		step = hit && ready_q && !small_step;

		upd.changed = init || step;
		if (init)
			upd.value = INIT_VALUE;
		else if (step)
			upd.value = value_new;
		else
			upd.value = value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			last_q  <= '0;
			acc_q   <= '0;
			value_q <= INIT_VALUE;
		end else if (commit) begin
			if (init) begin
				ready_q <= 1'b1;
				last_q  <= angle;
				acc_q   <= '0;
				value_q <= INIT_VALUE;
			end else if (step) begin
				last_q  <= angle;
				acc_q   <= acc_new;
				value_q <= value_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rotary_token_value_tracker.sv =====
// Rotary token value tracker: one result beat per report beat. A report is
// captured in an input register and evaluated from there against the three
// token rectangles and token states; the result lands in an output register
// when stage 1 advances. A new report is taken every cycle while results are
// being drained.
// The region registers may be written over the config channel while no report
// is in flight; cfg_ready is always high and indexes beyond 2 are ignored.
// depends on rtvt_pkg and rtvt_token
`timescale 1ns / 1ps
`default_nettype none

module rotary_token_value_tracker import rtvt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// report channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 report_complete,
	input  wire logic [7:0]           pos_x,
	input  wire logic [7:0]           pos_y,
	input  wire logic [ANGLE_W-1:0]   abs_angle,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [VALUE_W-1:0]        value_red,
	output logic [VALUE_W-1:0]        value_green,
	output logic [VALUE_W-1:0]        value_blue,
	output logic [NUM_TOKENS-1:0]     changed_mask,
	// config channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REGION_W-1:0]  cfg_data
);

	logic [REGION_W-1:0] region_q [NUM_TOKENS];

	logic                valid_s1;
	logic                complete_s1;
	logic [7:0]          x_s1;
	logic [7:0]          y_s1;
	logic [ANGLE_W-1:0]  angle_s1;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q [NUM_TOKENS];
	logic [NUM_TOKENS-1:0] mask_q;

	logic                advance;
	logic [NUM_TOKENS-1:0] hit;
	token_upd_t          upd [NUM_TOKENS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q[0] <= REGION_RED_RST;
			region_q[1] <= REGION_GREEN_RST;
			region_q[2] <= REGION_BLUE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_REGION_RED:   region_q[0] <= cfg_data;
				CFG_REGION_GREEN: region_q[1] <= cfg_data;
				CFG_REGION_BLUE:  region_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			complete_s1 <= report_complete;
			x_s1        <= pos_x;
			y_s1        <= pos_y;
			angle_s1    <= abs_angle;
		end
	end

	for (genvar i = 0; i < NUM_TOKENS; i++) begin : g_token
		assign hit[i] = complete_s1
			&& (x_s1 >= region_q[i][7:0])   && (x_s1 <= region_q[i][15:8])
			&& (y_s1 >= region_q[i][23:16]) && (y_s1 <= region_q[i][31:24]);

		rtvt_token u_token (
			.clk    (clk),
			.arst_n (arst_n),
			.hit    (hit[i]),
			.commit (advance),
			.angle  (angle_s1),
			.upd    (upd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NUM_TOKENS; i++) begin
				value_q[i] <= upd[i].value;
				mask_q[i]  <= upd[i].changed;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign value_red    = value_q[0];
	assign value_green  = value_q[1];
	assign value_blue   = value_q[2];
	assign changed_mask = mask_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for rotary_token_value_tracker: directed and random sensor reports,
// an in-file prediction of the three token values and changed mask, random stalls
// depends on rtvt_pkg and the rotary_token_value_tracker rtl
`timescale 1ns / 1ps

import rtvt_pkg::*;

typedef struct packed {
	logic [VALUE_W-1:0]    red;
	logic [VALUE_W-1:0]    green;
	logic [VALUE_W-1:0]    blue;
	logic [NUM_TOKENS-1:0] mask;
} token_values_t;

class token_scoreboard;
	logic [REGION_W-1:0] region[NUM_TOKENS];
	bit                  ready[NUM_TOKENS];
	int                  last_ang[NUM_TOKENS];
	int                  acc_ang[NUM_TOKENS];
	logic [VALUE_W-1:0]  value[NUM_TOKENS];
	token_values_t       expected_values[$];
	int                  errors;

	function new();
		region[0] = REGION_RED_RST;
		region[1] = REGION_GREEN_RST;
		region[2] = REGION_BLUE_RST;
		for (int t = 0; t < NUM_TOKENS; t++) begin
			ready[t]    = 1'b0;
			last_ang[t] = 0;
			acc_ang[t]  = 0;
			value[t]    = INIT_VALUE;
		end
		errors = 0;
	endfunction

	function void write_region(logic [CFG_IDX_W-1:0] idx, logic [REGION_W-1:0] data);
		if (idx <= CFG_REGION_BLUE)
			region[idx] = data;
	endfunction

	function int pending();
		return expected_values.size();
	endfunction

	// one accepted report beat moves the token state and yields one result
	function void track_report(bit complete, logic [7:0] x, logic [7:0] y,
			logic [ANGLE_W-1:0] ang);
		token_values_t       e;
		logic [REGION_W-1:0] r;
		int                  d;
		int                  s;
		e.mask = '0;
		if (complete) begin
			for (int t = 0; t < NUM_TOKENS; t++) begin
				r = region[t];
				if (x >= r[7:0] && x <= r[15:8] && y >= r[23:16] && y <= r[31:24]) begin
					if (!ready[t]) begin
						ready[t]    = 1'b1;
						last_ang[t] = int'(ang);
						acc_ang[t]  = 0;
						value[t]    = INIT_VALUE;
						e.mask[t]   = 1'b1;
					end else begin
						d = int'(ang) - last_ang[t];
						// unwrap across the 360 degree seam
						if (d > HALF_TURN || d < -HALF_TURN)
							d = (last_ang[t] > HALF_TURN) ? d + FULL_TURN : d - FULL_TURN;
						if (d > DEAD_BAND || d < -DEAD_BAND) begin
							s = acc_ang[t] + d;
							if (d > 0)
								acc_ang[t] = (s > HALF_TURN) ? int'(HALF_TURN) : s;
							else
								acc_ang[t] = (s < -HALF_TURN) ? -int'(HALF_TURN) : s;
							last_ang[t] = int'(ang);
							if (acc_ang[t] >= HALF_TURN)
								value[t] = MAX_VALUE;
							else
								value[t] = VALUE_W'(((acc_ang[t] + 2880) * 255 / 57600) * 10);
							e.mask[t] = 1'b1;
						end
					end
				end
			end
		end
		e.red   = value[0];
		e.green = value[1];
		e.blue  = value[2];
		expected_values.insert(expected_values.size(), e);
	endfunction

	function void check_values(logic [VALUE_W-1:0] red, logic [VALUE_W-1:0] green,
			logic [VALUE_W-1:0] blue, logic [NUM_TOKENS-1:0] mask);
		token_values_t e;
		if (expected_values.size() == 0) begin
			$error("result beat with no report pending");
			errors++;
			return;
		end
		e = expected_values.pop_front();
		if (red !== e.red) begin
			$error("value_red: expected %0d, got %0d", e.red, red);
			errors++;
		end
		if (green !== e.green) begin
			$error("value_green: expected %0d, got %0d", e.green, green);
			errors++;
		end
		if (blue !== e.blue) begin
			$error("value_blue: expected %0d, got %0d", e.blue, blue);
			errors++;
		end
		if (mask !== e.mask) begin
			$error("changed_mask: expected %b, got %b", e.mask, mask);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_ITEMS = 170;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  report_complete = 1'b0;
	logic [7:0]            pos_x = '0;
	logic [7:0]            pos_y = '0;
	logic [ANGLE_W-1:0]    abs_angle = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_W-1:0]    value_red;
	logic [VALUE_W-1:0]    value_green;
	logic [VALUE_W-1:0]    value_blue;
	logic [NUM_TOKENS-1:0] changed_mask;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [REGION_W-1:0]   cfg_data = '0;

	token_scoreboard     sb;
	logic [REGION_W-1:0] cur_region[NUM_TOKENS];
	int                  walk_angle[NUM_TOKENS];
	int                  burst_left = 0;
	bit                  steady = 1'b0;
	bit                  hold_req = 1'b0;

	rotary_token_value_tracker u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.report_complete(report_complete),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.abs_angle      (abs_angle),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value_red      (value_red),
		.value_green    (value_green),
		.value_blue     (value_blue),
		.changed_mask   (changed_mask),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic send_report(input bit complete, input logic [7:0] x, input logic [7:0] y,
			input logic [ANGLE_W-1:0] ang);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = steady ? 0 : $urandom_range(5, 0);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		report_complete <= complete;
		pos_x           <= x;
		pos_y           <= y;
		abs_angle       <= ang;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.track_report(complete, x, y, ang);
	endtask

	// stop offering reports and wait for every result beat to come back
	task automatic drain_reports();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_region(input logic [CFG_IDX_W-1:0] idx, input logic [REGION_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_region(idx, data);
		if (idx <= CFG_REGION_BLUE)
			cur_region[idx] = data;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// mostly a rotating token inside its own rectangle, the rest noise
	task automatic random_report();
		int                  kind;
		int                  t;
		int                  sel;
		int                  step;
		bit                  complete;
		logic [REGION_W-1:0] r;
		logic [7:0]          x;
		logic [7:0]          y;
		logic [ANGLE_W-1:0]  ang;
		kind = $urandom_range(99, 0);
		t = $urandom_range(NUM_TOKENS - 1, 0);
		r = cur_region[t];
		x = (r[7:0] <= r[15:8]) ? 8'($urandom_range(r[15:8], r[7:0])) : 8'($urandom_range(255, 0));
		y = (r[23:16] <= r[31:24]) ? 8'($urandom_range(r[31:24], r[23:16]))
			: 8'($urandom_range(255, 0));
		sel = $urandom_range(9, 0);
		if (sel < 2)
			step = $urandom_range(112, 0);
		else if (sel < 6)
			step = $urandom_range(400, 113);
		else if (sel < 9)
			step = $urandom_range(2880, 401);
		else
			step = $urandom_range(5759, 2881);
		if ($urandom_range(1, 0))
			step = -step;
		walk_angle[t] = (walk_angle[t] + step + 5760) % 5760;
		ang = ANGLE_W'(walk_angle[t]);
		complete = 1'b1;
		if (kind < 8) begin
			complete = 1'b0;
			ang = ANGLE_W'($urandom_range(8191, 0));
		end else if (kind < 16) begin
			x = 8'($urandom_range(255, 0));
			y = 8'($urandom_range(255, 0));
			ang = ANGLE_W'($urandom_range(8191, 0));
		end else if (kind < 20) begin
			ang = ANGLE_W'($urandom_range(8191, 5760));
		end
		send_report(complete, x, y, ang);
	endtask

	// result side: stall pattern switches between modes, plus one long hold-off
	initial begin : result_sink
		int mode;
		int left;
		int hold;
		int beat_no;
		bit stall;
		mode = 0;
		left = 0;
		hold = 0;
		beat_no = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 60;
			end
			if (left == 0) begin
				mode = $urandom_range(3, 0);
				left = $urandom_range(60, 10);
			end
			left--;
			beat_no++;
			case (mode)
				0: stall = 1'b0;
				1: stall = ($urandom_range(99, 0) < 30);
				2: stall = (beat_no % 5 < 2);
				default: stall = ($urandom_range(99, 0) < 75);
			endcase
			if (hold > 0) begin
				hold--;
				stall = 1'b1;
			end
			out_stall <= stall;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_values(value_red, value_green, value_blue, changed_mask);
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
					|| (cfg_valid && cfg_ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		cur_region[0] = REGION_RED_RST;
		cur_region[1] = REGION_GREEN_RST;
		cur_region[2] = REGION_BLUE_RST;
		for (int t = 0; t < NUM_TOKENS; t++)
			walk_angle[t] = $urandom_range(5759, 0);
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset rectangles: red 5..10 x 4..9, green 22..27 x 4..9, blue 22..27 x 20..25
		send_report(1'b0, 8'd5, 8'd4, 13'd100);
		send_report(1'b1, 8'd5, 8'd4, 13'd0);
		send_report(1'b1, 8'd10, 8'd9, 13'd112);
		send_report(1'b1, 8'd10, 8'd9, 13'd5648);
		send_report(1'b1, 8'd5, 8'd9, 13'd113);
		send_report(1'b1, 8'd5, 8'd9, 13'd2993);
		send_report(1'b1, 8'd5, 8'd9, 13'd5759);
		send_report(1'b1, 8'd5, 8'd9, 13'd100);
		send_report(1'b1, 8'd5, 8'd9, 13'd300);
		send_report(1'b1, 8'd5, 8'd9, 13'd5000);
		send_report(1'b1, 8'd5, 8'd9, 13'd2120);
		send_report(1'b1, 8'd5, 8'd9, 13'd8191);
		send_report(1'b1, 8'd5, 8'd9, 13'd5800);
		send_report(1'b1, 8'd22, 8'd4, 13'd5759);
		send_report(1'b1, 8'd27, 8'd9, 13'd0);
		send_report(1'b1, 8'd27, 8'd25, 13'd4000);
		send_report(1'b1, 8'd22, 8'd20, 13'd1000);
		send_report(1'b1, 8'd0, 8'd0, 13'd0);
		send_report(1'b1, 8'd255, 8'd255, 13'd8191);
		send_report(1'b0, 8'd255, 8'd255, 13'd8191);
		send_report(1'b1, 8'd11, 8'd9, 13'd50);
		send_report(1'b1, 8'd5, 8'd3, 13'd50);
		send_report(1'b1, 8'd5, 8'd10, 13'd50);
		drain_reports();

		// wide overlapping rectangles
		write_region(CFG_REGION_RED, 32'hFF00_FF00);
		write_region(CFG_REGION_GREEN, 32'h8000_8000);
		write_region(CFG_REGION_BLUE, 32'hFF40_FF40);
		repeat (PHASE_ITEMS) random_report();
		drain_reports();

		// single-point corners and an empty rectangle, plus an unmapped index
		write_region(CFG_REGION_RED, 32'h0000_0000);
		write_region(CFG_REGION_GREEN, 32'hFFFF_FFFF);
		write_region(CFG_REGION_BLUE, 32'h00FF_00FF);
		write_region(CFG_UNMAPPED, $urandom);
		repeat (PHASE_ITEMS) random_report();
		drain_reports();

		// random ordered rectangles, long hold-off on the result side
		for (int t = 0; t < NUM_TOKENS; t++) begin
			int lx;
			int ly;
			lx = $urandom_range(200, 0);
			ly = $urandom_range(200, 0);
			write_region(CFG_IDX_W'(t), {8'($urandom_range(255, ly)), 8'(ly),
				8'($urandom_range(255, lx)), 8'(lx)});
		end
		write_region(CFG_UNMAPPED, $urandom);
		hold_req = 1'b1;
		steady = 1'b1;
		repeat (40) random_report();
		steady = 1'b0;
		repeat (PHASE_ITEMS / 2) random_report();
		drain_reports();
		repeat (PHASE_ITEMS / 2) random_report();
		drain_reports();

		// back to the reset rectangles
		write_region(CFG_REGION_RED, REGION_RED_RST);
		write_region(CFG_REGION_GREEN, REGION_GREEN_RST);
		write_region(CFG_REGION_BLUE, REGION_BLUE_RST);
		repeat (PHASE_ITEMS) random_report();
		drain_reports();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/rtvt_pkg.sv
sv/rtvt_token.sv
sv/rotary_token_value_tracker.sv
test/testbench.sv
